// ----- rtl/core/phteg_pkg.sv -----
// ----------------------------------------------------------------------------
// phteg_pkg
// Shared types and codes for the pointer hit test and event generator.
// ----------------------------------------------------------------------------
package phteg_pkg;

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_WINDOW  = 2'd1;
    localparam logic [1:0] KIND_CONTROL = 2'd2;

    localparam logic [1:0] EV_HOVER  = 2'd0;
    localparam logic [1:0] EV_CLICK  = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;

    localparam logic [9:0] DCF_RESET = 10'd30;

    // control entry: id, parent, owner, x, y, w, h
    localparam int CTL_W = 94;

    typedef struct packed {
        logic [1:0]         etype;
        logic [15:0]        id;
        logic [5:0]         owner;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_event;

endpackage

// ----- rtl/core/phteg_ram.sv -----
// ----------------------------------------------------------------------------
// phteg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module phteg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/pointer_hit_test_event_generator_unit.sv -----
// ----------------------------------------------------------------------------
// pointer_hit_test_event_generator_unit
// Window and control tables with a pointer hit test and event generator.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall, one transfer per table write or pointer
// sample. Output channel: o_valid / i_stall, one transfer per event, the
// final event of a sample flagged by o_last_event.
// A pointer sample scans the control RAM from the top slot down, one slot per
// cycle through a pipelined compare, then reads the hovered control back
// through the single read port of the control RAM before the first event.
// Up to three events then follow, one per cycle while the receiver does not
// stall. o_stall is high from a sample's acceptance until its last event
// transfers, or until its event list is built if it has none; a stall on the
// output simply holds the current event.
// Reset clears the window active bits, the control valid bits, hover and click
// history, the frame counter and sets double_click_frames to 30. Control
// RAM contents are not cleared; its valid bits mark what is in use.
// ----------------------------------------------------------------------------
module pointer_hit_test_event_generator_unit
    import phteg_pkg::*;
#(
    parameter int NUM_CONTROLS  = 256,
    parameter int NUM_WINDOWS   = 32,
    parameter int NUM_PROCESSES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [9:0]         i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_slot,
    input  logic               i_entry_active,
    input  logic [15:0]        i_entry_id,
    input  logic [15:0]        i_parent_window_id,
    input  logic [5:0]         i_owner_process,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [11:0]        i_size_w,
    input  logic [11:0]        i_size_h,
    input  logic               i_entry_visible,
    input  logic               i_left_button,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_event_type,
    output logic [15:0]        o_event_control_id,
    output logic [5:0]         o_event_owner,
    output logic signed [15:0] o_event_x,
    output logic signed [15:0] o_event_y,
    output logic               o_last_event
);
    localparam int CW = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
    localparam int WW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam logic [10:0] NC11 = 11'(NUM_CONTROLS);
    localparam logic [8:0]  NW9  = 9'(NUM_WINDOWS);
    localparam logic [8:0]  NP9  = 9'(NUM_PROCESSES);
    localparam logic [CW-1:0] TOP = CW'(NUM_CONTROLS - 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_HREAD, S_HWAIT, S_OUT} t_state;

    t_state r_state;
    logic [9:0]  r_dcf;
    logic [31:0] r_frame, r_lc_frame;
    logic        r_prev_btn, r_hov_v, r_lc_v, r_hit_v, r_hov_act;
    logic [CW-1:0] r_hov_idx, r_lc_idx, r_hit_idx, r_cnt;
    logic [15:0] r_hit_id;
    logic [5:0]  r_hit_own;
    logic signed [15:0] r_px, r_py;
    logic        r_btn, r_issuing;
    logic [NUM_CONTROLS-1:0] r_ctl_valid;
    logic        r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    t_event      r_q [3];
    logic [1:0]  r_qn, r_rd;

    // window table
    logic               r_win_act [NUM_WINDOWS];
    logic [15:0]        r_win_id  [NUM_WINDOWS];
    logic signed [15:0] r_win_x   [NUM_WINDOWS];
    logic signed [15:0] r_win_y   [NUM_WINDOWS];
    logic               r_win_vis [NUM_WINDOWS];

    // pipeline payload
    logic [CW-1:0] r_p1_idx, r_p2_idx, r_p3_idx, r_p4_idx;
    logic          r_p1_act, r_p2_act;
    logic [NUM_WINDOWS-1:0] r_p2_match;
    logic [15:0]   r_p2_id, r_p3_id, r_p4_id;
    logic [5:0]    r_p2_own, r_p3_own, r_p4_own;
    logic signed [15:0] r_p2_gx, r_p2_gy, r_p3_gx, r_p3_gy;
    logic [11:0]   r_p2_w, r_p2_h, r_p3_w, r_p3_h, r_p4_w, r_p4_h;
    logic          r_p3_ok;
    logic signed [15:0] r_p3_wx, r_p3_wy;
    logic signed [16:0] r_p4_ax, r_p4_ay;
    logic          r_p4_ok;

    logic              accept, ram_we;
    logic [CW-1:0]     ram_raddr;
    logic [CTL_W-1:0]  ram_rdata;
    logic [NUM_WINDOWS-1:0] match;
    logic [WW-1:0]     sel;
    logic              sel_v;
    logic signed [17:0] ax_end, ay_end;
    logic              s4_hit;
    t_event            n_q [3];
    logic [1:0]        n_qn;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign ram_we  = accept && (i_kind == KIND_CONTROL) && ({3'b0, i_slot} < NC11);
    assign ram_raddr = (r_state == S_HREAD) ? r_hov_idx : r_cnt;

    phteg_ram #(.WIDTH(CTL_W), .DEPTH(NUM_CONTROLS), .AW(CW)) u_ctl_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (CW'(i_slot)),
        .i_wdata ({i_entry_id, i_parent_window_id, i_owner_process,
                   i_pos_x, i_pos_y, i_size_w, i_size_h}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int j = 0; j < NUM_WINDOWS; j++) begin
            match[j] = r_win_act[j] && (r_win_id[j] == ram_rdata[77:62]);
        end
    end

    always_comb begin
        sel   = '0;
        sel_v = 1'b0;
        for (int j = NUM_WINDOWS - 1; j >= 0; j--) begin
            if (r_p2_match[j]) begin
                sel   = WW'(j);
                sel_v = 1'b1;
            end
        end
    end

    assign ax_end = 18'(r_p4_ax) + $signed({6'b0, r_p4_w});
    assign ay_end = 18'(r_p4_ay) + $signed({6'b0, r_p4_h});
    assign s4_hit = r_p4_v && r_p4_ok &&
                    (17'(r_px) >= r_p4_ax) && (18'(r_px) < ax_end) &&
                    (17'(r_py) >= r_p4_ay) && (18'(r_py) < ay_end);

    // event list for the sample
    always_comb begin
        logic changed;
        logic dbl;
        t_event ev;
        ev   = '0;
        n_qn = 2'd0;
        for (int k = 0; k < 3; k++) begin
            n_q[k] = r_q[k];
        end
        changed = (r_hit_v != r_hov_v) || (r_hit_v && r_hit_idx != r_hov_idx);
        if (changed && r_hov_v && r_hov_act && ({3'b0, ram_rdata[61:56]} < NP9)) begin
            ev.etype = EV_HOVER;
            ev.id    = ram_rdata[93:78];
            ev.owner = ram_rdata[61:56];
            ev.x     = '0;
            ev.y     = '0;
            n_q[n_qn] = ev;
            n_qn = n_qn + 2'd1;
        end
        if (changed && r_hit_v && ({3'b0, r_hit_own} < NP9)) begin
            ev.etype = EV_HOVER;
            ev.id    = r_hit_id;
            ev.owner = r_hit_own;
            ev.x     = r_px;
            ev.y     = r_py;
            n_q[n_qn] = ev;
            n_qn = n_qn + 2'd1;
        end
        dbl = r_lc_v && (r_lc_idx == r_hit_idx) &&
              ((r_frame - r_lc_frame) < {22'b0, r_dcf});
        if (r_btn && !r_prev_btn && r_hit_v && ({3'b0, r_hit_own} < NP9)) begin
            ev.etype = dbl ? EV_DOUBLE : EV_CLICK;
            ev.id    = r_hit_id;
            ev.owner = r_hit_own;
            ev.x     = r_px;
            ev.y     = r_py;
            n_q[n_qn] = ev;
            n_qn = n_qn + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dcf       <= DCF_RESET;
            r_frame     <= '0;
            r_lc_frame  <= '0;
            r_prev_btn  <= 1'b0;
            r_hov_v     <= 1'b0;
            r_lc_v      <= 1'b0;
            r_hit_v     <= 1'b0;
            r_issuing   <= 1'b0;
            r_ctl_valid <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_p4_v      <= 1'b0;
            r_qn        <= '0;
            r_rd        <= '0;
            for (int j = 0; j < NUM_WINDOWS; j++) begin
                r_win_act[j] <= 1'b0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_dcf <= i_cfg_wr_data;
            end
            r_p1_v <= r_issuing;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            if (s4_hit && !r_hit_v) begin
                r_hit_v   <= 1'b1;
                r_hit_idx <= r_p4_idx;
                r_hit_id  <= r_p4_id;
                r_hit_own <= r_p4_own;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_kind)
                            KIND_WINDOW: begin
                                if ({1'b0, i_slot} < NW9) begin
                                    r_win_act[WW'(i_slot)] <= i_entry_active;
                                end
                            end
                            KIND_CONTROL: begin
                                if (ram_we) begin
                                    r_ctl_valid[CW'(i_slot)] <= i_entry_active;
                                end
                            end
                            KIND_SAMPLE: begin
                                r_frame   <= r_frame + 32'd1;
                                r_px      <= i_pos_x;
                                r_py      <= i_pos_y;
                                r_btn     <= i_left_button;
                                r_cnt     <= TOP;
                                r_hit_v   <= 1'b0;
                                r_issuing <= 1'b1;
                                r_state   <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_cnt == '0) begin
                        r_issuing <= 1'b0;
                        r_state   <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v && !r_p3_v && !r_p4_v) begin
                        r_state <= S_HREAD;
                    end
                end
                S_HREAD: begin
                    r_hov_act <= r_hov_v && r_ctl_valid[r_hov_idx];
                    r_state   <= S_HWAIT;
                end
                S_HWAIT: begin
                    for (int k = 0; k < 3; k++) begin
                        r_q[k] <= n_q[k];
                    end
                    r_qn       <= n_qn;
                    r_rd       <= '0;
                    r_hov_v    <= r_hit_v;
                    r_hov_idx  <= r_hit_idx;
                    r_prev_btn <= r_btn;
                    if (r_btn && !r_prev_btn && r_hit_v) begin
                        r_lc_v     <= 1'b1;
                        r_lc_idx   <= r_hit_idx;
                        r_lc_frame <= r_frame;
                    end
                    r_state <= (n_qn == 2'd0) ? S_IDLE : S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_rd <= r_rd + 2'd1;
                        if (r_rd == r_qn - 2'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // window payload and pipeline payload
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == KIND_WINDOW && ({1'b0, i_slot} < NW9)) begin
            r_win_id[WW'(i_slot)]  <= i_entry_id;
            r_win_x[WW'(i_slot)]   <= i_pos_x;
            r_win_y[WW'(i_slot)]   <= i_pos_y;
            r_win_vis[WW'(i_slot)] <= i_entry_visible;
        end
        r_p1_idx   <= r_cnt;
        r_p1_act   <= r_ctl_valid[r_cnt];
        r_p2_idx   <= r_p1_idx;
        r_p2_act   <= r_p1_act;
        r_p2_match <= match;
        r_p2_id    <= ram_rdata[93:78];
        r_p2_own   <= ram_rdata[61:56];
        r_p2_gx    <= ram_rdata[55:40];
        r_p2_gy    <= ram_rdata[39:24];
        r_p2_w     <= ram_rdata[23:12];
        r_p2_h     <= ram_rdata[11:0];
        r_p3_idx   <= r_p2_idx;
        r_p3_ok    <= r_p2_act && sel_v && r_win_vis[sel];
        r_p3_wx    <= r_win_x[sel];
        r_p3_wy    <= r_win_y[sel];
        r_p3_id    <= r_p2_id;
        r_p3_own   <= r_p2_own;
        r_p3_gx    <= r_p2_gx;
        r_p3_gy    <= r_p2_gy;
        r_p3_w     <= r_p2_w;
        r_p3_h     <= r_p2_h;
        r_p4_idx   <= r_p3_idx;
        r_p4_ok    <= r_p3_ok;
        r_p4_ax    <= 17'(r_p3_wx) + 17'(r_p3_gx);
        r_p4_ay    <= 17'(r_p3_wy) + 17'(r_p3_gy);
        r_p4_id    <= r_p3_id;
        r_p4_own   <= r_p3_own;
        r_p4_w     <= r_p3_w;
        r_p4_h     <= r_p3_h;
    end

    assign o_valid            = (r_state == S_OUT);
    assign o_event_type       = r_q[r_rd].etype;
    assign o_event_control_id = r_q[r_rd].id;
    assign o_event_owner      = r_q[r_rd].owner;
    assign o_event_x          = r_q[r_rd].x;
    assign o_event_y          = r_q[r_rd].y;
    assign o_last_event       = (r_rd == r_qn - 2'd1);
endmodule

// ----- rtl/core/phteg_checker.sv -----
// ----------------------------------------------------------------------------
// phteg_checker
// Port level checks for the pointer hit test and event generator.
// ----------------------------------------------------------------------------
module phteg_checker
    import phteg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_event_type,
    input logic [15:0] o_event_control_id,
    input logic        o_last_event
);
    // held event stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_type)
                               && $stable(o_event_control_id))
        else $error("stalled event changed");

    // no input transfer while events are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while events pending");

    a_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_type == EV_HOVER || o_event_type == EV_CLICK
                     || o_event_type == EV_DOUBLE))
        else $error("bad event type");

    // after the last event of a sample the block is idle
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_event |=> !o_valid && !o_stall)
        else $error("block not idle after last event");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active after reset");
endmodule

bind pointer_hit_test_event_generator_unit phteg_checker u_phteg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_event_type       (o_event_type),
    .o_event_control_id (o_event_control_id),
    .o_last_event       (o_last_event)
);
